// ----- hw/rtl/servo_instruction_packet_framer_defines.svh -----
// Assertion macros for the servo instruction packet framer.
// Used by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef SERVO_INSTRUCTION_PACKET_FRAMER_DEFINES_SVH
`define SERVO_INSTRUCTION_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that is also evaluated across reset.
`define SIPF_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sipf_pkg.sv -----
// Shared types and constants of the servo instruction packet framer.
// No dependencies; used by the front end, queue, back end and top level.
package sipf_pkg;

  localparam logic [7:0]  HDR_BYTE   = 8'hFF;
  localparam logic [7:0]  GOAL_ADDR  = 8'd30;
  localparam logic [7:0]  GOAL_INSTR = 8'd3;
  localparam logic [7:0]  GOAL_LEN   = 8'd7;
  localparam logic [15:0] GOAL_LIMIT = 16'd1023;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_BYTES   = 11;
  localparam int IDX_W       = $clog2(MAX_BYTES);

  // Input item kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PARAM  = 2'd1;
  localparam logic [1:0] KIND_GOAL   = 2'd2;

  // Job codes passed from front to back
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_PARAM  = 2'd1;
  localparam logic [1:0] OP_GOAL   = 2'd2;
  localparam logic [1:0] OP_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       with_chk;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] instr;
    logic [7:0] pb;
    logic [7:0] pos_lo;
    logic [7:0] pos_hi;
    logic [7:0] spd_lo;
    logic [7:0] spd_hi;
    logic [7:0] chk;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- hw/rtl/sipf_if.sv -----
// Valid/ready channel interfaces of the servo instruction packet framer.
// No dependencies.
interface sipf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  servo_id;
  logic [7:0]  instruction;
  logic [7:0]  param_count;
  logic [7:0]  param_byte;
  logic [15:0] position;
  logic [15:0] speed;

  modport source (output valid, kind, servo_id, instruction, param_count, param_byte,
                  position, speed, input ready);
  modport sink   (input valid, kind, servo_id, instruction, param_count, param_byte,
                  position, speed, output ready);
endinterface

interface sipf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;
  logic       rejected;

  modport source (output valid, tx_byte, last, rejected, input ready);
  modport sink   (input valid, tx_byte, last, rejected, output ready);
endinterface

// ----- hw/rtl/sipf_front.sv -----
// Front end: accepts requests, tracks the open packet and queues byte jobs.
// Depends on sipf_pkg and sipf_if.
module sipf_front (
  input  logic                   clk,
  input  logic                   rst,
  sipf_cmd_if.sink               cmd,
  input  sipf_pkg::queue_status_t qstat,
  output logic                   push,
  output sipf_pkg::job_t         job
);

  logic       packet_open, packet_open_next;
  logic [7:0] params_left, params_left_next;
  logic [7:0] sum_acc, sum_acc_next;

  logic [7:0] len;
  logic [7:0] hdr_sum;
  logic [7:0] par_sum;
  logic [7:0] par_left;
  logic [7:0] goal_sum;
  logic       goal_bad;

  assign cmd.ready = !qstat.full;
  assign push      = cmd.valid && cmd.ready;

  assign len      = cmd.param_count + 8'd2;
  assign hdr_sum  = cmd.servo_id + len + cmd.instruction;
  assign par_sum  = sum_acc + cmd.param_byte;
  assign par_left = params_left - 8'd1;
  assign goal_sum = cmd.servo_id + sipf_pkg::GOAL_LEN + sipf_pkg::GOAL_INSTR
                  + sipf_pkg::GOAL_ADDR + cmd.position[7:0] + cmd.position[15:8]
                  + cmd.speed[7:0] + cmd.speed[15:8];
  assign goal_bad = (cmd.position > sipf_pkg::GOAL_LIMIT)
                 || (cmd.speed > sipf_pkg::GOAL_LIMIT);

  always_comb begin
    job              = '0;
    job.op           = sipf_pkg::OP_REJECT;
    packet_open_next = packet_open;
    params_left_next = params_left;
    sum_acc_next     = sum_acc;
    unique case (cmd.kind)
      sipf_pkg::KIND_HEADER: begin
        job.op       = sipf_pkg::OP_HEADER;
        job.id       = cmd.servo_id;
        job.len      = len;
        job.instr    = cmd.instruction;
        job.chk      = ~hdr_sum;
        job.with_chk = (cmd.param_count == 8'd0);
        sum_acc_next = hdr_sum;
        packet_open_next = (cmd.param_count != 8'd0);
        params_left_next = cmd.param_count;
      end
      sipf_pkg::KIND_PARAM: begin
        if (packet_open && params_left != 8'd0) begin
          job.op       = sipf_pkg::OP_PARAM;
          job.pb       = cmd.param_byte;
          job.chk      = ~par_sum;
          job.with_chk = (par_left == 8'd0);
          sum_acc_next     = par_sum;
          params_left_next = par_left;
          packet_open_next = (par_left != 8'd0);
        end
      end
      sipf_pkg::KIND_GOAL: begin
        if (!goal_bad) begin
          job.op       = sipf_pkg::OP_GOAL;
          job.id       = cmd.servo_id;
          job.pos_lo   = cmd.position[7:0];
          job.pos_hi   = cmd.position[15:8];
          job.spd_lo   = cmd.speed[7:0];
          job.spd_hi   = cmd.speed[15:8];
          job.chk      = ~goal_sum;
          job.with_chk = 1'b1;
          sum_acc_next     = goal_sum;
          packet_open_next = 1'b0;
          params_left_next = 8'd0;
        end
      end
      default: begin
        job.op = sipf_pkg::OP_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      params_left <= 8'd0;
      sum_acc     <= 8'd0;
    end else if (push) begin
      packet_open <= packet_open_next;
      params_left <= params_left_next;
      sum_acc     <= sum_acc_next;
    end
  end

endmodule

// ----- hw/rtl/sipf_queue.sv -----
// Short job queue between front and back ends, built from registers.
// Depends on sipf_pkg and the assertion macro header.
`include "servo_instruction_packet_framer_defines.svh"

module sipf_queue #(
  parameter int DEPTH = sipf_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sipf_pkg::job_t          wr_job,
  input  logic                    pop,
  output sipf_pkg::job_t          head,
  output sipf_pkg::queue_status_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sipf_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SIPF_ASSERT_NOW(a_no_push_full, qstat.full, !push, "push into full queue")
  `SIPF_ASSERT_NOW(a_no_pop_empty, qstat.empty, !pop, "pop from empty queue")
  `SIPF_ASSERT_NOW(a_count_range, 1'b1, count <= FULL_CNT, "queue count out of range")

endmodule

// ----- hw/rtl/sipf_back.sv -----
// Back end: serializes queued jobs into transmit bytes, one per cycle while tx is not stalled.
// Depends on sipf_pkg, sipf_if and the assertion macro header.
`include "servo_instruction_packet_framer_defines.svh"

module sipf_back (
  input  logic                    clk,
  input  logic                    rst,
  input  sipf_pkg::job_t          head,
  input  sipf_pkg::queue_status_t qstat,
  output logic                    pop,
  sipf_tx_if.source               tx
);

  logic [sipf_pkg::IDX_W-1:0] idx;
  logic [sipf_pkg::IDX_W-1:0] nbytes;
  logic [7:0]                 cur_byte;
  logic                       load;
  logic                       final_byte;

  always_comb begin
    unique case (head.op)
      sipf_pkg::OP_HEADER: nbytes = head.with_chk ? sipf_pkg::IDX_W'(6) : sipf_pkg::IDX_W'(5);
      sipf_pkg::OP_PARAM:  nbytes = head.with_chk ? sipf_pkg::IDX_W'(2) : sipf_pkg::IDX_W'(1);
      sipf_pkg::OP_GOAL:   nbytes = sipf_pkg::IDX_W'(sipf_pkg::MAX_BYTES);
      default:             nbytes = sipf_pkg::IDX_W'(1);
    endcase
  end

  always_comb begin
    cur_byte = 8'd0;
    unique case (head.op)
      sipf_pkg::OP_HEADER: begin
        case (idx)
          4'd0, 4'd1: cur_byte = sipf_pkg::HDR_BYTE;
          4'd2:       cur_byte = head.id;
          4'd3:       cur_byte = head.len;
          4'd4:       cur_byte = head.instr;
          default:    cur_byte = head.chk;
        endcase
      end
      sipf_pkg::OP_PARAM: begin
        cur_byte = (idx == '0) ? head.pb : head.chk;
      end
      sipf_pkg::OP_GOAL: begin
        case (idx)
          4'd0, 4'd1: cur_byte = sipf_pkg::HDR_BYTE;
          4'd2:       cur_byte = head.id;
          4'd3:       cur_byte = sipf_pkg::GOAL_LEN;
          4'd4:       cur_byte = sipf_pkg::GOAL_INSTR;
          4'd5:       cur_byte = sipf_pkg::GOAL_ADDR;
          4'd6:       cur_byte = head.pos_lo;
          4'd7:       cur_byte = head.pos_hi;
          4'd8:       cur_byte = head.spd_lo;
          4'd9:       cur_byte = head.spd_hi;
          default:    cur_byte = head.chk;
        endcase
      end
      default: cur_byte = 8'd0;
    endcase
  end

  assign load       = !tx.valid || tx.ready;
  assign final_byte = (idx == nbytes - 1'b1);
  assign pop        = load && !qstat.empty && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      tx.valid <= !qstat.empty;
      if (!qstat.empty) begin
        idx <= final_byte ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      tx.tx_byte  <= cur_byte;
      tx.last     <= final_byte;
      tx.rejected <= (head.op == sipf_pkg::OP_REJECT);
    end
  end

  `SIPF_ASSERT_NOW(a_rej_last, tx.valid && tx.rejected, tx.last, "rejected byte not last")
  `SIPF_ASSERT_NOW(a_idx_range, !qstat.empty, idx < nbytes, "byte index past job end")
  `SIPF_ASSERT_ALWAYS(a_reset_idle, $past(rst), !tx.valid, "output valid after reset")

endmodule

// ----- hw/rtl/servo_instruction_packet_framer.sv -----
// Top level of the servo instruction packet framer: front end, job queue, back end.
// Depends on sipf_pkg, sipf_if, sipf_front, sipf_queue and sipf_back.
//
// Usage:
//   cmd carries requests: kind 0 opens a packet (FF FF id count+2 instruction),
//   kind 1 adds one parameter byte, kind 2 builds a full goal position packet.
//   tx carries the transmit bytes, one per handshake on tx, with last on the final
//   byte of each request and rejected on the single byte of a refused request.
// When the queue was empty and the output register free, the first byte of a request
//   is written into a queue entry at acceptance and then into the output register.
// Throughput: the back end emits one byte per cycle while tx is not stalled; a request
//   yields 11 bytes for a goal command, 5 or 6 for a header, 1 or 2 for a
//   parameter, 1 for a rejection.
// The front end updates packet state at acceptance and takes a new request every
//   cycle while the job queue (QUEUE_DEPTH entries) has room; cmd.ready drops
//   only when the queue is full.
// Reset (synchronous, rst high) closes any open packet, clears the running sum,
//   empties the queue and drops tx.valid.
// When the receiver stalls, tx holds its byte; the back end stops, the queue
//   fills and then cmd.ready is lowered. No request or byte is lost.
module servo_instruction_packet_framer #(
  parameter int QUEUE_DEPTH = sipf_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  sipf_cmd_if.sink  cmd,
  sipf_tx_if.source tx
);

  sipf_pkg::job_t          wr_job;
  sipf_pkg::job_t          head;
  sipf_pkg::queue_status_t qstat;
  logic                    push;
  logic                    pop;

  // Classify requests and keep the open-packet state
  sipf_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .qstat (qstat),
    .push  (push),
    .job   (wr_job)
  );

  // Decouple acceptance from transmission
  sipf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  // Serialize jobs into the output register
  sipf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .tx    (tx)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for servo_instruction_packet_framer: a directed table, then random requests.
// Depends on sipf_pkg, the sipf_cmd_if / sipf_tx_if interfaces and the framer RTL.
module tb;

  // The kind field is two bits wide, so code 3 reaches the block and must be refused.
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam int RANDOM_REQUESTS = 156;
  localparam int RESET_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 150;
  // Slowest correct run: ~190 requests x 11 bytes, each byte waiting out a long receiver
  // stall, plus the hold-off; the limit allows several times that.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_LIMIT     = 20000;
  // Leave room after the drain for anything stray.
  localparam int TAIL_CYCLES     = 20;

  // Idle mix, stepped through as the run progresses.
  typedef enum int {
    PH_RX_SLOW,    // sender idles 26 %, receiver 52 %
    PH_TX_SLOW,    // sender idles 52 %, receiver 26 %
    PH_FULL_RATE   // nobody idles
  } idle_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  servo_id;
    logic [7:0]  instruction;
    logic [7:0]  param_count;
    logic [7:0]  param_byte;
    logic [15:0] position;
    logic [15:0] speed;
  } request_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       rejected;
  } tx_beat_t;

  // One row of the stimulus table; n_known > 0 means the bytes are typed in by hand.
  typedef struct packed {
    request_t   req;
    logic [3:0] n_known;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sipf_cmd_if cmd ();
  sipf_tx_if  tx ();

  servo_instruction_packet_framer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .tx  (tx)
  );

  // Framing state of the predictor.
  logic       pkt_open;
  logic [7:0] params_left;
  logic [7:0] running_sum;

  tx_beat_t    framed[$];          // bytes framed for the request just accepted
  tx_beat_t    pending_bytes[$];   // bytes still owed by the block, oldest first
  tx_beat_t    known_bytes[$];     // hand-typed bytes of the directed table
  stim_row_t   stim_rows[$];
  tx_beat_t    oldest;

  idle_phase_t idle_phase     = PH_RX_SLOW;
  bit          hold_done      = 1'b0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void emit(input logic [7:0] b, input logic lst);
    framed.push_back('{tx_byte: b, last: lst, rejected: 1'b0});
  endfunction

  function automatic void emit_reject();
    framed.push_back('{tx_byte: 8'h00, last: 1'b1, rejected: 1'b1});
  endfunction

  // Frame one accepted request into framed[] and advance the packet state.
  function automatic void frame_request(input request_t r);
    logic [7:0] len;
    logic [7:0] goal_sum;
    framed.delete();
    case (r.kind)
      sipf_pkg::KIND_HEADER: begin
        len = r.param_count + 8'd2;       // wraps for counts above 253
        emit(sipf_pkg::HDR_BYTE, 1'b0);
        emit(sipf_pkg::HDR_BYTE, 1'b0);
        emit(r.servo_id, 1'b0);
        emit(len, 1'b0);
        emit(r.instruction, r.param_count != 8'd0);
        running_sum = r.servo_id + len + r.instruction;
        if (r.param_count == 8'd0) begin
          // Nothing to wait for: close the packet with its checksum now.
          emit(~running_sum, 1'b1);
          pkt_open    = 1'b0;
          params_left = 8'd0;
        end else begin
          pkt_open    = 1'b1;
          params_left = r.param_count;
        end
      end
      sipf_pkg::KIND_PARAM: begin
        if (!pkt_open || params_left == 8'd0) begin
          emit_reject();
        end else begin
          running_sum = running_sum + r.param_byte;
          params_left = params_left - 8'd1;
          emit(r.param_byte, params_left != 8'd0);
          if (params_left == 8'd0) begin
            emit(~running_sum, 1'b1);
            pkt_open = 1'b0;
          end
        end
      end
      sipf_pkg::KIND_GOAL: begin
        // Out of range leaves the state alone, an open packet included.
        if (r.position > sipf_pkg::GOAL_LIMIT || r.speed > sipf_pkg::GOAL_LIMIT) begin
          emit_reject();
        end else begin
          goal_sum = r.servo_id + sipf_pkg::GOAL_LEN + sipf_pkg::GOAL_INSTR
                   + sipf_pkg::GOAL_ADDR
                   + r.position[7:0] + r.position[15:8] + r.speed[7:0] + r.speed[15:8];
          emit(sipf_pkg::HDR_BYTE, 1'b0);
          emit(sipf_pkg::HDR_BYTE, 1'b0);
          emit(r.servo_id, 1'b0);
          emit(sipf_pkg::GOAL_LEN, 1'b0);
          emit(sipf_pkg::GOAL_INSTR, 1'b0);
          emit(sipf_pkg::GOAL_ADDR, 1'b0);
          emit(r.position[7:0], 1'b0);
          emit(r.position[15:8], 1'b0);
          emit(r.speed[7:0], 1'b0);
          emit(r.speed[15:8], 1'b0);
          emit(~goal_sum, 1'b1);
          pkt_open    = 1'b0;
          params_left = 8'd0;
          running_sum = goal_sum;
        end
      end
      default: emit_reject();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic request_t mk(input logic [1:0] k, input logic [7:0] id,
                                  input logic [7:0] instr, input logic [7:0] cnt,
                                  input logic [7:0] pb, input logic [15:0] pos,
                                  input logic [15:0] spd);
    return '{kind: k, servo_id: id, instruction: instr, param_count: cnt,
             param_byte: pb, position: pos, speed: spd};
  endfunction

  // Every field random, so that unused fields toggle too; the kind is given.
  function automatic request_t rand_req(input logic [1:0] k);
    request_t r;
    r = request_t'({2'b00, $urandom, $urandom});
    r.kind = k;
    return r;
  endfunction

  function automatic void add_row(input request_t r, input logic [3:0] n_known);
    stim_rows.push_back('{req: r, n_known: n_known});
  endfunction

  function automatic void known_byte(input logic [7:0] b, input logic lst);
    known_bytes.push_back('{tx_byte: b, last: lst, rejected: 1'b0});
  endfunction

  function automatic void known_reject();
    known_bytes.push_back('{tx_byte: 8'h00, last: 1'b1, rejected: 1'b1});
  endfunction

  function automatic bit idles(input bit receiver);
    int pct;
    case (idle_phase)
      PH_RX_SLOW: pct = receiver ? 52 : 26;
      PH_TX_SLOW: pct = receiver ? 26 : 52;
      default:    pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: build the table, reset, drive requests, drain, report.
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    request_t  r;
    stim_row_t row;
    int        sel;
    int        cnt;
    int        sent;
    int        n_random;
    int        accepted;
    int        drain_cycles;

    // Hold every input at a known value from time zero.
    cmd.valid       = 1'b0;
    cmd.kind        = sipf_pkg::KIND_HEADER;
    cmd.servo_id    = 8'h00;
    cmd.instruction = 8'h00;
    cmd.param_count = 8'h00;
    cmd.param_byte  = 8'h00;
    cmd.position    = 16'h0000;
    cmd.speed       = 16'h0000;
    pkt_open        = 1'b0;
    params_left     = 8'd0;
    running_sum     = 8'd0;

    // Directed table. Typed rows give the bytes outright; the rest go to the predictor.
    // Stray parameter straight out of reset: refuse it.
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000), 1);
    known_reject();
    // Unknown kind with every field at its maximum.
    add_row(mk(KIND_UNKNOWN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 1);
    known_reject();
    // Zero-count header: checksum ~(1 + 2 + 3) follows the header at once.
    add_row(mk(sipf_pkg::KIND_HEADER, 8'h01, 8'h03, 8'h00, 8'h00, 16'h0000, 16'h0000), 6);
    known_byte(sipf_pkg::HDR_BYTE, 1'b0); known_byte(sipf_pkg::HDR_BYTE, 1'b0);
    known_byte(8'h01, 1'b0);    known_byte(8'h02, 1'b0);
    known_byte(8'h03, 1'b0);    known_byte(8'hF9, 1'b1);
    // Largest legal count: length byte 255, packet stays open.
    add_row(mk(sipf_pkg::KIND_HEADER, 8'hFF, 8'hFF, 8'd253, 8'h00, 16'h0000, 16'h0000), 5);
    known_byte(sipf_pkg::HDR_BYTE, 1'b0); known_byte(sipf_pkg::HDR_BYTE, 1'b0);
    known_byte(8'hFF, 1'b0);    known_byte(8'hFF, 1'b0);
    known_byte(8'hFF, 1'b1);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0000, 16'h0000), 0);
    // Goal out of range, position then speed: refuse, keep the open packet.
    add_row(mk(sipf_pkg::KIND_GOAL, 8'h12, 8'h00, 8'h00, 8'h00, 16'd1024, 16'd0), 1);
    known_reject();
    add_row(mk(sipf_pkg::KIND_GOAL, 8'h12, 8'h00, 8'h00, 8'h00, 16'd0, 16'd1024), 1);
    known_reject();
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h5A, 16'h0000, 16'h0000), 0);
    // Count above 253 abandons the open packet; length wraps to 1.
    add_row(mk(sipf_pkg::KIND_HEADER, 8'h00, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000), 5);
    known_byte(sipf_pkg::HDR_BYTE, 1'b0); known_byte(sipf_pkg::HDR_BYTE, 1'b0);
    known_byte(8'h00, 1'b0);    known_byte(8'h01, 1'b0);
    known_byte(8'h00, 1'b1);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h01, 16'h0000, 16'h0000), 0);
    // Goal at zero abandons the open packet; checksum is ~(7 + 3 + 30).
    add_row(mk(sipf_pkg::KIND_GOAL, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0), 11);
    known_byte(sipf_pkg::HDR_BYTE, 1'b0); known_byte(sipf_pkg::HDR_BYTE, 1'b0);
    known_byte(8'h00, 1'b0);
    known_byte(sipf_pkg::GOAL_LEN, 1'b0); known_byte(sipf_pkg::GOAL_INSTR, 1'b0);
    known_byte(sipf_pkg::GOAL_ADDR, 1'b0);
    known_byte(8'h00, 1'b0);    known_byte(8'h00, 1'b0);    known_byte(8'h00, 1'b0);
    known_byte(8'h00, 1'b0);    known_byte(8'hD7, 1'b1);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000), 1);
    known_reject();
    add_row(mk(sipf_pkg::KIND_GOAL, 8'hFF, 8'h00, 8'h00, 8'h00, 16'd1023, 16'd1023), 0);
    add_row(mk(sipf_pkg::KIND_GOAL, 8'h21, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF), 1);
    known_reject();
    // Short packets run to their checksum, then a stray parameter.
    add_row(mk(sipf_pkg::KIND_HEADER, 8'h10, 8'h02, 8'd1, 8'h00, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'hAA, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h3C, 16'h0000, 16'h0000), 1);
    known_reject();
    add_row(mk(sipf_pkg::KIND_HEADER, 8'h7E, 8'h83, 8'd2, 8'h00, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h01, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'hFE, 16'h0000, 16'h0000), 0);
    // Count 254 wraps the length to 0; then abandon it with a fresh header.
    add_row(mk(sipf_pkg::KIND_HEADER, 8'h80, 8'h04, 8'd254, 8'h00, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h80, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_HEADER, 8'h01, 8'h01, 8'd3, 8'h00, 16'h0000, 16'h0000), 0);
    add_row(mk(sipf_pkg::KIND_PARAM, 8'h00, 8'h00, 8'h00, 8'h55, 16'h0000, 16'h0000), 0);

    // Random part: mostly well-formed packets with random content, the rest noise.
    n_random = 0;
    while (n_random < RANDOM_REQUESTS) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        // Header followed by its parameters; sometimes cut short.
        r   = rand_req(sipf_pkg::KIND_HEADER);
        sel = $urandom_range(0, 9);
        if (sel < 7)      cnt = $urandom_range(0, 4);
        else if (sel < 9) cnt = $urandom_range(5, 12);
        else              cnt = $urandom_range(200, 255);
        r.param_count = 8'(cnt);
        add_row(r, 0);
        n_random++;
        sent = cnt;
        if (cnt > 12) sent = $urandom_range(0, 6);
        else if (cnt > 0 && $urandom_range(0, 99) < 15) sent = $urandom_range(0, cnt - 1);
        repeat (sent) begin
          add_row(rand_req(sipf_pkg::KIND_PARAM), 0);
          n_random++;
        end
      end else if (sel < 70) begin
        r          = rand_req(sipf_pkg::KIND_GOAL);
        r.position = 16'($urandom_range(0, 1023));
        r.speed    = 16'($urandom_range(0, 1023));
        add_row(r, 0);
        n_random++;
      end else begin
        r = rand_req(sipf_pkg::KIND_PARAM);   // stray parameter unless overridden below
        case ($urandom_range(0, 3))
          0: ;
          1: r.kind = KIND_UNKNOWN;
          2: begin
            r.kind = sipf_pkg::KIND_GOAL;
            if ($urandom_range(0, 1) == 0) r.position = 16'($urandom_range(1024, 65535));
            else                           r.speed    = 16'($urandom_range(1024, 65535));
          end
          default: r.kind = 2'($urandom_range(0, 3));
        endcase
        add_row(r, 0);
        n_random++;
      end
    end

    // Hold reset for a fixed stretch, release it on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    accepted = 0;
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      // Idle at random before offering the request.
      while (idles(1'b0)) begin
        cmd.valid <= 1'b0;
        @(negedge clk);
      end
      cmd.valid       <= 1'b1;
      cmd.kind        <= row.req.kind;
      cmd.servo_id    <= row.req.servo_id;
      cmd.instruction <= row.req.instruction;
      cmd.param_count <= row.req.param_count;
      cmd.param_byte  <= row.req.param_byte;
      cmd.position    <= row.req.position;
      cmd.speed       <= row.req.speed;
      // Wait for the handshake at a rising edge.
      do @(posedge clk); while (!cmd.ready);
      // Advance the predictor at acceptance; typed rows override its bytes.
      frame_request(row.req);
      if (row.n_known != 4'd0) begin
        repeat (row.n_known) pending_bytes.push_back(known_bytes.pop_front());
      end else begin
        foreach (framed[k]) pending_bytes.push_back(framed[k]);
      end
      accepted++;
      if (accepted * 3 >= stim_rows.size() * 2) idle_phase = PH_FULL_RATE;
      else if (accepted * 3 >= stim_rows.size()) idle_phase = PH_TX_SLOW;
      @(negedge clk);
    end
    cmd.valid <= 1'b0;

    // Drain what is still owed, then leave room for stray bytes.
    drain_cycles = 0;
    while (pending_bytes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $error("%0d expected tx bytes never arrived", pending_bytes.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls by phase, and one long hold-off once the sender runs
  // at full rate, so the job queue fills and cmd.ready drops.
  // ---------------------------------------------------------------------------

  initial begin : receiver
    tx.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (idle_phase == PH_FULL_RATE && !hold_done) begin
        tx.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        tx.ready <= !idles(1'b1);
        @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte checker: compare every accepted byte with the oldest one owed.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && tx.valid && tx.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("tx_byte %h arrived with nothing expected", tx.tx_byte);
        mismatch_count++;
      end else begin
        oldest = pending_bytes.pop_front();
        if (tx.tx_byte !== oldest.tx_byte) begin
          $error("tx_byte: expected %h, actual %h", oldest.tx_byte, tx.tx_byte);
          mismatch_count++;
        end
        if (tx.last !== oldest.last) begin
          $error("last: expected %b, actual %b", oldest.last, tx.last);
          mismatch_count++;
        end
        if (tx.rejected !== oldest.rejected) begin
          $error("rejected: expected %b, actual %b", oldest.rejected, tx.rejected);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule
